### rtl/core/sha512_pkg.sv
// Shared constants, types and functions of the SHA-512 hash core.
package sha512_pkg;

    localparam int WORD_W   = 64;
    localparam int BLK_W    = 16;
    localparam int DIG_W    = 8;
    localparam int ROUNDS   = 80;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;

    // Word moved from the front (padding) to the back (compression).
    typedef struct packed {
        logic [63:0] word;
        logic        last;   // final word of the padded message
    } blk_beat_t;

    typedef logic [63:0] word_arr_t [8];

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0: init_hash = 64'h6a09e667f3bcc908;
            3'd1: init_hash = 64'hbb67ae8584caa73b;
            3'd2: init_hash = 64'h3c6ef372fe94f82b;
            3'd3: init_hash = 64'ha54ff53a5f1d36f1;
            3'd4: init_hash = 64'h510e527fade682d1;
            3'd5: init_hash = 64'h9b05688c2b3e6c1f;
            3'd6: init_hash = 64'h1f83d9abfb41bd6b;
            default: init_hash = 64'h5be0cd19137e2179;
        endcase
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k [80];
        k = '{
            64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
            64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
            64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
            64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
            64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
            64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
            64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
            64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
            64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
            64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
            64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
            64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
            64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
            64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
            64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
            64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
            64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
            64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
            64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
            64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
        };
        round_k = (t < 7'd80) ? k[t] : 64'd0;
    endfunction

endpackage

### rtl/core/sha512_if.sv
// Valid/ready channel interfaces for message words and digest words.
interface sha512_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] message_word;
    logic [3:0]  bytes_valid;
    logic        last_word;
    modport source (output valid, message_word, bytes_valid, last_word, input ready);
    modport sink (input valid, message_word, bytes_valid, last_word, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic        digest_last;
    modport source (output valid, digest_word, digest_last, input ready);
    modport sink (input valid, digest_word, digest_last, output ready);
endinterface

### rtl/core/sha512_front.sv
// Front end: length count, byte masking and padding word generation.
module sha512_front
    import sha512_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    sha512_in_if.sink        in_ch,
    output logic             beat_valid,
    input  logic             beat_ready,
    output blk_beat_t        beat
);
    typedef enum logic [1:0] {S_PASS, S_PAD0, S_LENHI, S_LEN} state_t;

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic        pad_pending_reg, pad_pending_next;  // full last word: pad byte still owed
    logic [3:0]  nb;
    logic [63:0] keep;
    logic [63:0] masked;
    logic        fire;

    assign nb = (in_ch.bytes_valid > 4'd8) ? 4'd8 : in_ch.bytes_valid;
    assign keep = (nb == 4'd0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> {nb, 3'b000});
    assign masked = (in_ch.message_word & keep) | (PAD_WORD >> {nb, 3'b000});
    assign fire = beat_valid && beat_ready;

    always_comb
    begin
        in_ch.ready = 1'b0;
        beat_valid = 1'b0;
        beat = '{word: 64'd0, last: 1'b0};
        state_next = state_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        pad_pending_next = pad_pending_reg;
        case (state_reg)
            S_PASS:
            begin
                in_ch.ready = beat_ready;
                beat_valid = in_ch.valid;
                if (!in_ch.last_word)
                begin
                    beat.word = in_ch.message_word;
                end
                else if (nb == 4'd8)
                begin
                    beat.word = in_ch.message_word;
                end
                else
                begin
                    beat.word = masked;
                end
                if (fire)
                begin
                    pos_next = pos_reg + 4'd1;
                    if (!in_ch.last_word)
                    begin
                        len_next = len_reg + 64'd64;
                    end
                    else
                    begin
                        len_next = len_reg + {57'd0, nb, 3'b000};
                        pad_pending_next = (nb == 4'd8);
                        state_next = S_PAD0;
                    end
                end
            end
            S_PAD0:
            begin
                beat_valid = 1'b1;
                beat.word = pad_pending_reg ? PAD_WORD : 64'd0;
                if (pos_reg == 4'd14 && !pad_pending_reg)
                begin
                    state_next = S_LENHI;
                    beat_valid = 1'b0;
                end
                else if (fire)
                begin
                    pos_next = pos_reg + 4'd1;
                    pad_pending_next = 1'b0;
                end
            end
            S_LENHI:
            begin
                beat_valid = 1'b1;
                if (fire)
                begin
                    pos_next = pos_reg + 4'd1;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                beat_valid = 1'b1;
                beat.word = len_reg;
                beat.last = 1'b1;
                if (fire)
                begin
                    pos_next = 4'd0;
                    len_next = 64'd0;
                    state_next = S_PASS;
                end
            end
            default: state_next = S_PASS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_PASS;
            pos_reg <= 4'd0;
            len_reg <= 64'd0;
            pad_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            pad_pending_reg <= pad_pending_next;
        end
    end
endmodule

### rtl/core/sha512_queue.sv
// Short FIFO between the padding front end and the compression back end.
module sha512_queue
    import sha512_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  blk_beat_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output blk_beat_t rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    blk_beat_t             mem [DEPTH];
    logic [AW-1:0]         wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;
    logic                  do_wr, do_rd;

    assign wr_ready = (cnt_reg != DEPTH[$clog2(DEPTH+1)-1:0]);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data = mem[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (do_wr ? 1'b1 : 1'b0) - (do_rd ? 1'b1 : 1'b0);
        end
    end
endmodule

### rtl/core/sha512_back.sv
// Back end: block buffer, 80-round compression and digest word output.
module sha512_back
    import sha512_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       beat_valid,
    output logic       beat_ready,
    input  blk_beat_t  beat,
    sha512_out_if.source out_ch
);
    typedef enum logic [1:0] {S_FILL, S_ROUND, S_ADD, S_EMIT} state_t;

    state_t      state_reg;
    logic [63:0] win_reg [16];       // block words, then schedule window
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [3:0]  pos_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  oidx_reg;
    logic        fin_reg;            // block holds the length word
    logic        oval_reg;
    logic [63:0] oword_reg;
    logic        olast_reg;

    logic [63:0] w, s0, s1, t1, t2, wa, wb;
    logic [3:0]  ti;

    assign beat_ready = (state_reg == S_FILL);
    assign ti = rnd_reg[3:0];
    assign wa = win_reg[ti + 4'd1];
    assign wb = win_reg[ti + 4'd14];
    assign s0 = rotr(wa, 1) ^ rotr(wa, 8) ^ (wa >> 7);
    assign s1 = rotr(wb, 19) ^ rotr(wb, 61) ^ (wb >> 6);
    assign w = (rnd_reg < 7'd16) ? win_reg[ti]
             : win_reg[ti] + s0 + win_reg[ti + 4'd9] + s1;
    assign t1 = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + w;
    assign t2 = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign out_ch.valid = oval_reg;
    assign out_ch.digest_word = oword_reg;
    assign out_ch.digest_last = olast_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FILL && beat_valid)
        begin
            win_reg[pos_reg] <= beat.word;
        end
        else if (state_reg == S_ROUND)
        begin
            win_reg[ti] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_hash(3'(i));
                v_reg[i] <= 64'd0;
            end
            pos_reg <= 4'd0;
            rnd_reg <= 7'd0;
            oidx_reg <= 3'd0;
            fin_reg <= 1'b0;
            oval_reg <= 1'b0;
            oword_reg <= 64'd0;
            olast_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_FILL:
                begin
                    if (beat_valid)
                    begin
                        pos_reg <= pos_reg + 4'd1;
                        if (pos_reg == 4'd15)
                        begin
                            fin_reg <= beat.last;
                            rnd_reg <= 7'd0;
                            for (int i = 0; i < 8; i++)
                            begin
                                v_reg[i] <= h_reg[i];
                            end
                            state_reg <= S_ROUND;
                        end
                    end
                end
                S_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'(ROUNDS - 1))
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (fin_reg)
                    begin
                        oidx_reg <= 3'd0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_FILL;
                    end
                end
                S_EMIT:
                begin
                    if (!oval_reg || out_ch.ready)
                    begin
                        oval_reg <= 1'b1;
                        oword_reg <= h_reg[oidx_reg];
                        olast_reg <= (oidx_reg == 3'd7);
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= init_hash(3'(i));
                            end
                            state_reg <= S_FILL;
                        end
                    end
                end
                default: state_reg <= S_FILL;
            endcase
            if (state_reg != S_EMIT && oval_reg && out_ch.ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end
endmodule

### rtl/core/sha512_hash_core_unit.sv
// SHA-512 hash core top level: padding front end, queue, compression back end.
// A block is filled with 16 words, compressed in 80 rounds and added into the hash.
// The single shared round unit does one round a cycle, and the back end takes no
//   words of a new block until the current block has been added into the hash.
// After the last word, padding adds up to 18 beats, then 8 digest beats follow.
// Reset (rst_n low, async) loads the initial hash and clears length and counts.
module sha512_hash_core_unit
    import sha512_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    sha512_in_if.sink     in_ch,
    sha512_out_if.source  out_ch
);
    logic      f_valid, f_ready, b_valid, b_ready;
    blk_beat_t f_beat, b_beat;

    // Front: count length, mask the last word, and generate the pad beats.
    sha512_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .beat_valid (f_valid),
        .beat_ready (f_ready),
        .beat       (f_beat)
    );

    // Queue: lets the front keep accepting while the rounds run.
    sha512_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_beat),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_beat)
    );

    // Back: fill a block, compress, and emit the digest on the last block.
    sha512_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (b_valid),
        .beat_ready (b_ready),
        .beat       (b_beat),
        .out_ch     (out_ch)
    );
endmodule

### rtl/core/sha512_checker.sv
// Port-level checker for the SHA-512 hash core, bound to the top level.
module sha512_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_word,
    input logic        out_last
);
    logic [2:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else if (out_valid && out_ready)
        begin
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("digest beat dropped while stalled");
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (cnt_reg == 3'd7)))
        else $error("digest_last off the eighth beat");
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid || !out_last)
        else $error("two last beats in a row");
endmodule

bind sha512_hash_core_unit sha512_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.digest_word),
    .out_last  (out_ch.digest_last)
);
